// ===== design/skslt_pkg.sv =====
// Shared types and constants for the sorted key to slot index block.
// Used by every module of the block; depends on nothing.
package skslt_pkg;

  localparam int ENTRIES     = 2048;
  localparam int KEY_W       = 32;
  localparam int SLOT_W      = $clog2(ENTRIES);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int LVLS        = SLOT_W;
  localparam int LEAVES      = 1 << LVLS;
  localparam int TREE_CNT_W  = $clog2(LVLS + 1);
  localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ERASED  = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_TREE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } cell_t;

  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              ers;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } cell_ctl_t;

endpackage

// ===== design/skslt_cell.sv =====
// One cell of the sorted key chain: holds one key and its slot.
// Depends on skslt_pkg.
module skslt_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  skslt_pkg::cell_ctl_t            ctl,
  input  skslt_pkg::cell_t                prev,
  input  logic                            lt_prev,
  input  skslt_pkg::cell_t                next,
  output skslt_pkg::cell_t                cur,
  output logic                            lt,
  output logic [skslt_pkg::SLOT_W:0]      leaf
);

  skslt_pkg::cell_t cur_next;
  logic             eq;

  // A cell below the new key keeps its entry; the first cell at or above it
  // takes the new key, and the rest move up by one. Erase moves entries down.
  always_comb begin
    cur_next = cur;
    if (ctl.ins && !lt) begin
      if (lt_prev) begin
        cur_next.valid = 1'b1;
        cur_next.key   = ctl.key;
        cur_next.slot  = ctl.slot;
      end else begin
        cur_next = prev;
      end
    end else if (ctl.ers && !lt) begin
      cur_next = next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
    cur.key  <= cur_next.key;
    cur.slot <= cur_next.slot;
    if (ctl.cmp) begin
      lt <= cur.valid && (cur.key < ctl.key);
      eq <= cur.valid && (cur.key == ctl.key);
    end
  end

  assign leaf = eq ? {1'b1, cur.slot} : '0;

endmodule

// ===== design/skslt_or_tree.sv =====
// Registered OR tree that collects the single matching cell's slot.
// Depends on skslt_pkg.
module skslt_or_tree (
  input  logic                       clk,
  input  logic [skslt_pkg::SLOT_W:0] leaves [skslt_pkg::ENTRIES],
  output logic [skslt_pkg::SLOT_W:0] root
);

  logic [skslt_pkg::SLOT_W:0] leaf_pad [skslt_pkg::LEAVES];
  logic [skslt_pkg::SLOT_W:0] node     [1:skslt_pkg::LEAVES-1];

  for (genvar i = 0; i < skslt_pkg::LEAVES; i++) begin : g_pad
    if (i < skslt_pkg::ENTRIES) begin : g_real
      assign leaf_pad[i] = leaves[i];
    end else begin : g_zero
      assign leaf_pad[i] = '0;
    end
  end

  for (genvar n = 1; n < skslt_pkg::LEAVES; n++) begin : g_node
    if (2 * n >= skslt_pkg::LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node[n] <= leaf_pad[2*n-skslt_pkg::LEAVES] | leaf_pad[2*n+1-skslt_pkg::LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[n] <= node[2*n] | node[2*n+1];
      end
    end
  end

  assign root = node[1];

endmodule

// ===== design/skslt_free_stack.sv =====
// Stack of free slot numbers, addressed by depth from the top of stack.
// Unwritten depths read as their reset value. Depends on skslt_pkg.
module skslt_free_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [skslt_pkg::CNT_W-1:0]   rd_depth,
  output logic [skslt_pkg::SLOT_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [skslt_pkg::SLOT_W-1:0]  wr_depth,
  input  logic [skslt_pkg::SLOT_W-1:0]  wr_data
);

  logic [skslt_pkg::SLOT_W-1:0] mem [skslt_pkg::ENTRIES];
  logic [skslt_pkg::SLOT_W-1:0] mem_q;
  logic [skslt_pkg::SLOT_W-1:0] depth_q;
  logic                         hit_q;
  logic [skslt_pkg::CNT_W-1:0]  fill;
  logic [skslt_pkg::CNT_W-1:0]  wr_top;

  // Writes always land at the depth just above the live keys, so every depth
  // below the fill count, one past the deepest write, is written before it is read.
  assign wr_top = {1'b0, wr_depth} + skslt_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && (wr_top > fill)) begin
      fill <= wr_top;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_depth] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_depth[skslt_pkg::SLOT_W-1:0]];
      depth_q <= rd_depth[skslt_pkg::SLOT_W-1:0];
      hit_q   <= rd_depth < fill;
    end
  end

  assign rd_data = hit_q ? mem_q : depth_q;

endmodule

// ===== design/sorted_key_slot_index.sv =====
// Sorted key to slot index: a chain of key cells, an OR tree and a free stack.
// Depends on skslt_pkg, skslt_cell, skslt_or_tree and skslt_free_stack.
//
//   Channel   Dir   Signals                      Contents
//   s_axis    in    tvalid tready tdata tuser    request: key, opcode
//   m_axis    out   tvalid tready tdata tuser    result: slot, status
//
// Each request steps through the compare state, the tree states that wait out
// the registered OR tree over all cells, and then the apply state.
// Requests are taken one at a time; s_axis_tready is high only when idle.
// A result waiting on m_axis_tready holds the block before its update.
// Synchronous reset empties the table and restores the free stack at once.
module sorted_key_slot_index (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [skslt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key
  input  logic                                 s_axis_tuser,  // opcode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [skslt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // slot
  output logic [2:0]                           m_axis_tuser   // status
);

  skslt_pkg::state_t  state, state_next;
  logic                              op;
  logic [skslt_pkg::KEY_W-1:0]       key;
  logic [skslt_pkg::CNT_W-1:0]       count, count_next;
  logic [skslt_pkg::TREE_CNT_W-1:0]  tree_cnt, tree_cnt_next;
  skslt_pkg::status_t                out_status, out_status_next;
  logic [skslt_pkg::SLOT_W-1:0]      out_slot, out_slot_next;
  logic                              out_load;
  logic                              accept;
  logic                              stk_rd;
  logic                              stk_wr;
  logic [skslt_pkg::SLOT_W-1:0]      stk_data;
  logic [skslt_pkg::SLOT_W-1:0]      stk_wr_depth;
  logic [skslt_pkg::SLOT_W:0]        root;
  skslt_pkg::cell_ctl_t              ctl;

  skslt_pkg::cell_t              cells  [skslt_pkg::ENTRIES];
  logic                          lts    [skslt_pkg::ENTRIES];
  logic [skslt_pkg::SLOT_W:0]    leaves [skslt_pkg::ENTRIES];

  assign s_axis_tready = (state == skslt_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign stk_wr_depth  = skslt_pkg::SLOT_W'(count - skslt_pkg::CNT_W'(1));

  for (genvar i = 0; i < skslt_pkg::ENTRIES; i++) begin : g_cell
    skslt_pkg::cell_t prev_c, next_c;
    logic             lt_prev;
    if (i == 0) begin : g_first
      assign prev_c  = '0;
      assign lt_prev = 1'b1;
    end else begin : g_mid
      assign prev_c  = cells[i-1];
      assign lt_prev = lts[i-1];
    end
    if (i == skslt_pkg::ENTRIES - 1) begin : g_last
      assign next_c = '0;
    end else begin : g_body
      assign next_c = cells[i+1];
    end
    skslt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .prev    (prev_c),
      .lt_prev (lt_prev),
      .next    (next_c),
      .cur     (cells[i]),
      .lt      (lts[i]),
      .leaf    (leaves[i])
    );
  end

  skslt_or_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  skslt_free_stack u_stack (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (stk_rd),
    .rd_depth (count),
    .rd_data  (stk_data),
    .wr_en    (stk_wr),
    .wr_depth (stk_wr_depth),
    .wr_data  (root[skslt_pkg::SLOT_W-1:0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= skslt_pkg::S_IDLE;
      count         <= '0;
      tree_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      tree_cnt <= tree_cnt_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_axis_tuser;
      key <= s_axis_tdata[skslt_pkg::KEY_W-1:0];
    end
    if (out_load) begin
      out_status <= out_status_next;
      out_slot   <= out_slot_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    tree_cnt_next   = tree_cnt;
    out_load        = 1'b0;
    out_status_next = skslt_pkg::ST_MISSING;
    out_slot_next   = '0;
    stk_rd          = 1'b0;
    stk_wr          = 1'b0;
    ctl             = '0;
    ctl.key         = key;
    ctl.slot        = stk_data;
    case (state)
      skslt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = skslt_pkg::S_CMP;
        end
      end
      skslt_pkg::S_CMP: begin
        ctl.cmp       = 1'b1;
        stk_rd        = 1'b1;
        tree_cnt_next = '0;
        state_next    = skslt_pkg::S_TREE;
      end
      skslt_pkg::S_TREE: begin
        tree_cnt_next = tree_cnt + skslt_pkg::TREE_CNT_W'(1);
        if (tree_cnt == skslt_pkg::TREE_CNT_W'(skslt_pkg::LVLS - 1)) begin
          state_next = skslt_pkg::S_APPLY;
        end
      end
      skslt_pkg::S_APPLY: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = skslt_pkg::S_IDLE;
          if (op == skslt_pkg::OP_INSERT) begin
            if (count == skslt_pkg::CNT_W'(skslt_pkg::ENTRIES)) begin
              out_status_next = skslt_pkg::ST_FULL;
            end else if (root[skslt_pkg::SLOT_W]) begin
              out_status_next = skslt_pkg::ST_PRESENT;
              out_slot_next   = root[skslt_pkg::SLOT_W-1:0];
            end else begin
              out_status_next = skslt_pkg::ST_NEW;
              out_slot_next   = stk_data;
              ctl.ins         = 1'b1;
              count_next      = count + skslt_pkg::CNT_W'(1);
            end
          end else begin
            if (root[skslt_pkg::SLOT_W]) begin
              out_status_next = skslt_pkg::ST_ERASED;
              out_slot_next   = root[skslt_pkg::SLOT_W-1:0];
              ctl.ers         = 1'b1;
              stk_wr          = 1'b1;
              count_next      = count - skslt_pkg::CNT_W'(1);
            end else begin
              out_status_next = skslt_pkg::ST_MISSING;
            end
          end
        end
      end
      default: begin
        state_next = skslt_pkg::S_IDLE;
      end
    endcase
  end

  assign m_axis_tdata = skslt_pkg::OUT_TDATA_W'(out_slot);
  assign m_axis_tuser = out_status;

endmodule

// ===== design/skslt_checker.sv =====
// Port-level checks for the sorted key to slot index block, bound to its top.
// Depends on skslt_pkg and sorted_key_slot_index.
module skslt_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [skslt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input logic                                 s_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [skslt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input logic [2:0]                           m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result changed while stalled.");

  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == skslt_pkg::ST_FULL ||
                      m_axis_tuser == skslt_pkg::ST_MISSING) |->
      m_axis_tdata == '0)
    else $error("Failed request carries a nonzero slot.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Request taken while another is in flight.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("Result shown right after reset.");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata >> skslt_pkg::SLOT_W) == '0)
    else $error("Slot padding bits are not zero.");

endmodule

bind sorted_key_slot_index skslt_checker u_skslt_checker (.*);
